/* hdl/qfts_pkg.sv */
// ----------------------------------------------------------------------------
// qfts_pkg: shared types and constants for the two-stack queue
// Operation codes, the controller state encoding and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package qfts_pkg;

  localparam int VALUE_W = 32;

  // Operation codes carried in the op field of an input word
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Answer given by a dequeue that finds the queue empty
  localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_XFER_RD = 5'b00010,
    ST_XFER_WR = 5'b00100,
    ST_POP_RD  = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic push_in;     // write the request value on top of the input stack
    logic in_rd;       // read the input stack top and drop it
    logic out_wr;      // push the word just read from the input stack
    logic out_rd;      // read the output stack top and drop it
    logic mark_empty;  // next result is the empty answer
    logic emit;        // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_empty;
    logic in_full;
    logic out_empty;
    logic rsp_free;
  } status_t;

endpackage

/* hdl/qfts_if.sv */
// ----------------------------------------------------------------------------
// qfts_req_if / qfts_rsp_if: request and response channels
// Valid/ready channels; a word moves at a rising edge with valid and ready high.
// ----------------------------------------------------------------------------
interface qfts_req_if
  import qfts_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               op;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface qfts_rsp_if
  import qfts_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] front_value;
  logic               was_empty;

  modport source (output valid, output front_value, output was_empty, input ready);
  modport sink (input valid, input front_value, input was_empty, output ready);
endinterface

/* hdl/qfts_ram.sv */
// ----------------------------------------------------------------------------
// qfts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module qfts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/qfts_datapath.sv */
// ----------------------------------------------------------------------------
// qfts_datapath: stack stores, stack counts and result register
// Two RAMs hold the stacks; the counts give each top; the result register
// parts the work from the receiver.
// ----------------------------------------------------------------------------
module qfts_datapath
  import qfts_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [VALUE_W-1:0] req_value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [VALUE_W-1:0] rsp_front_value,
  output logic               rsp_was_empty
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]      in_top;
  logic [CW-1:0]      out_top;
  logic [CW-1:0]      in_below;
  logic [CW-1:0]      out_below;
  logic [VALUE_W-1:0] in_rdata;
  logic [VALUE_W-1:0] out_rdata;
  logic               empty_sel;

  assign in_below  = in_top - CW'(1);
  assign out_below = out_top - CW'(1);

  qfts_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_in_ram (
    .clk   (clk),
    .we    (cmd.push_in),
    .waddr (in_top[AW-1:0]),
    .wdata (req_value),
    .re    (cmd.in_rd),
    .raddr (in_below[AW-1:0]),
    .rdata (in_rdata)
  );

  qfts_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_out_ram (
    .clk   (clk),
    .we    (cmd.out_wr),
    .waddr (out_top[AW-1:0]),
    .wdata (in_rdata),
    .re    (cmd.out_rd),
    .raddr (out_below[AW-1:0]),
    .rdata (out_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_top  <= '0;
      out_top <= '0;
    end else begin
      if (cmd.push_in) begin
        in_top <= in_top + CW'(1);
      end else if (cmd.in_rd) begin
        in_top <= in_below;
      end
      if (cmd.out_wr) begin
        out_top <= out_top + CW'(1);
      end else if (cmd.out_rd) begin
        out_top <= out_below;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_sel <= 1'b0;
    end else if (cmd.mark_empty) begin
      empty_sel <= 1'b1;
    end else if (cmd.out_rd) begin
      empty_sel <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_front_value <= empty_sel ? EMPTY_VALUE : out_rdata;
      rsp_was_empty   <= empty_sel;
    end
  end

  assign status.in_empty  = (in_top == '0);
  assign status.in_full   = (in_top == CW'(STACK_DEPTH));
  assign status.out_empty = (out_top == '0);
  assign status.rsp_free  = !rsp_valid || rsp_ready;

endmodule

/* hdl/qfts_ctrl.sv */
// ----------------------------------------------------------------------------
// qfts_ctrl: queue controller
// Takes request words, sequences the stack-to-stack transfer and the pop,
// and hands the result to the datapath's result register.
// ----------------------------------------------------------------------------
module qfts_ctrl
  import qfts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  logic    req_op,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_op == OP_ENQ) begin
            // drop the word when the input stack is full
            cmd.push_in = !status.in_full;
          end else if (!status.out_empty) begin
            state_next = ST_POP_RD;
          end else if (!status.in_empty) begin
            state_next = ST_XFER_RD;
          end else begin
            cmd.mark_empty = 1'b1;
            state_next     = ST_EMIT;
          end
        end
      end
      ST_XFER_RD: begin
        cmd.in_rd  = 1'b1;
        state_next = ST_XFER_WR;
      end
      ST_XFER_WR: begin
        cmd.out_wr = 1'b1;
        state_next = status.in_empty ? ST_POP_RD : ST_XFER_RD;
      end
      ST_POP_RD: begin
        cmd.out_rd = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register is free
        if (status.rsp_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/queue_from_two_stacks.sv */
// ----------------------------------------------------------------------------
// queue_from_two_stacks: first-in first-out queue built from two stacks
// Enqueue pushes onto the input stack; dequeue pops the output stack, first
// refilling it from the input stack in reversed order when it is empty.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per operation: op selects enqueue or dequeue, value
//   is the element to enqueue (ignored on dequeue). rsp carries one word per
//   dequeue: front_value and was_empty. An enqueue gives no rsp word.
//   An enqueue onto a full input stack is dropped without any answer.
//   A dequeue on an empty queue answers all ones with was_empty high.
// Sequencing:
//   An enqueue is taken in ST_IDLE; req.ready stays high afterwards.
//   Dequeue with a filled output stack: ST_POP_RD, then ST_EMIT; rsp.valid
//   rises on leaving ST_EMIT, and req.ready returns with it. Empty queue:
//   ST_EMIT alone. A dequeue that refills the output stack first runs the
//   transfer loop, ST_XFER_RD then ST_XFER_WR per moved element, reading one
//   RAM and writing the other. A dequeue holds off req until its result is
//   emitted; each element moves once between the stacks.
// Reset (rst, synchronous): both stacks become empty and rsp.valid drops.
// Stall: a result waits in the output register while rsp.ready is low;
//   enqueues keep flowing, and a following dequeue holds in its last step
//   until that register is free.
// ----------------------------------------------------------------------------
module queue_from_two_stacks
  import qfts_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input logic        clk,
  input logic        rst,
  qfts_req_if.sink   req,
  qfts_rsp_if.source rsp
);

  cmd_t    cmd;
  status_t status;

  // control: handshake and stack sequencing
  qfts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_op    (req.op),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: stack RAMs, counts and result register
  qfts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_value       (req.value),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_front_value (rsp.front_value),
    .rsp_was_empty   (rsp.was_empty)
  );

endmodule

/* hdl/qfts_checker.sv */
// ----------------------------------------------------------------------------
// qfts_checker: port-level checks for the two-stack queue
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module qfts_checker
  import qfts_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [VALUE_W-1:0] rsp_front_value,
  input logic               rsp_was_empty
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_front_value)
      && $stable(rsp_was_empty))
    else $error("result word changed while stalled");

  // the empty answer is always all ones
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_was_empty |-> rsp_front_value == EMPTY_VALUE)
    else $error("empty answer without all-ones value");

  // an accepted request cannot raise a result on the next edge
  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result appeared one cycle after a request");

  // a fresh result follows a cycle in which requests were held off
  a_rsp_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result rose while the queue was idle");

endmodule

bind queue_from_two_stacks qfts_checker u_qfts_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_front_value (rsp.front_value),
  .rsp_was_empty   (rsp.was_empty)
);
